// ===== design/tdpt_pkg.sv =====
// ---------------------------------------------------------------------------
// tdpt_pkg: shared constants for the trial division prime test
// Default operand width used by the top level and the divider unit.
// ---------------------------------------------------------------------------
`default_nettype none

package tdpt_pkg;

	// default width of the number under test
	localparam int unsigned VALUE_WIDTH_DEF = 32;

	// smallest prime, and the first odd trial divisor
	localparam int unsigned SMALLEST_PRIME = 2;
	localparam int unsigned FIRST_DIVISOR  = 3;

	// odd divisors advance by this step
	localparam int unsigned DIVISOR_STEP   = 2;

endpackage : tdpt_pkg

`default_nettype wire

// ===== design/trial_division_prime_test_top.sv =====
// ---------------------------------------------------------------------------
// trial_division_prime_test_top: trial division primality test
// Tests one unsigned number against odd divisors 3, 5, 7, ... using a
// shared bit-serial divider, and reports whether it is prime.
// ---------------------------------------------------------------------------
//  channel  | ports                | handshake
//  ---------+----------------------+------------------------------------
//  in       | value_n              | taken when start=1 and busy=0
//  out      | is_prime             | valid for one cycle while done=1
//
//  For n below three or even n, the check state decides the result and
//  raises done. Odd n runs one divider pass per odd divisor tried (up to
//  about sqrt(n)/2 divisors), each pass followed by a handoff through the
//  sequencer. busy falls in the cycle done is high, so the next item can
//  be taken at the edge that ends it.
//  Reset returns the sequencer to idle; a running test is dropped.
//  The result cannot be held off by the receiver.
// ---------------------------------------------------------------------------
`default_nettype none

module trial_division_prime_test_top #(
	parameter int unsigned VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire logic [VALUE_WIDTH-1:0] value_n,
	output logic                        done,
	output logic                        is_prime
);
	import tdpt_pkg::*;

	localparam int unsigned W = VALUE_WIDTH;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_DIV
	} state_t;

	state_t       state_q;
	logic [W-1:0] n_q;
	logic [W-1:0] k_q;
	logic         go_q;
	logic         done_q;
	logic         prime_q;

	logic         div_done;
	logic [W-1:0] div_quot;
	logic [W-1:0] div_rem;

	// shared divider: n / k
	tdpt_div #(
		.W (W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go_q),
		.dividend  (n_q),
		.divisor   (k_q),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	// sequencer: special cases, then one divider pass per odd candidate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			go_q    <= 1'b0;
			done_q  <= 1'b0;
			prime_q <= 1'b0;
		end else begin
			go_q   <= 1'b0;
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (n_q[W-1:1] == '0) begin
						// zero and one
						prime_q <= 1'b0;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (n_q == W'(SMALLEST_PRIME)) begin
						prime_q <= 1'b1;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (!n_q[0]) begin
						// even above two
						prime_q <= 1'b0;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						go_q    <= 1'b1;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						if (k_q > div_quot) begin
							// k*k > n: no divisor left
							prime_q <= 1'b1;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else if (div_rem == '0) begin
							prime_q <= 1'b0;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							go_q <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// operand and candidate registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			n_q <= value_n;
		end
		if (state_q == S_CHECK) begin
			k_q <= W'(FIRST_DIVISOR);
		end else if (state_q == S_DIV && div_done) begin
			k_q <= k_q + W'(DIVISOR_STEP);
		end
	end

	assign busy     = (state_q != S_IDLE);
	assign done     = done_q;
	assign is_prime = prime_q;

endmodule : trial_division_prime_test_top

`default_nettype wire

// ===== design/tdpt_div.sv =====
// ---------------------------------------------------------------------------
// tdpt_div: bit-serial restoring divider
// Produces quotient and remainder of dividend / divisor, one quotient bit
// per cycle; done pulses for one cycle as the last quotient bit is stored.
// ---------------------------------------------------------------------------
`default_nettype none

module tdpt_div #(
	parameter int unsigned W = tdpt_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         go,
	input  wire logic [W-1:0] dividend,
	input  wire logic [W-1:0] divisor,
	output logic              done,
	output logic [W-1:0]      quotient,
	output logic [W-1:0]      remainder
);
	import tdpt_pkg::*;

	localparam int unsigned CW = $clog2(W + 1);

	logic          active_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  qd_q;     // dividend bits shift out, quotient bits shift in

	logic [W:0]    trial;
	logic [W:0]    diff;
	logic          fits;

	// one restoring step: shift in next dividend bit, subtract if it fits
	always_comb begin
		trial = {rem_q, qd_q[W-1]};
		diff  = trial - {1'b0, divisor};
		fits  = (trial >= {1'b0, divisor});
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				active_q <= 1'b1;
				cnt_q    <= CW'(W);
			end else if (active_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			qd_q  <= dividend;
		end else if (active_q) begin
			rem_q <= fits ? diff[W-1:0] : trial[W-1:0];
			qd_q  <= {qd_q[W-2:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = qd_q;
	assign remainder = rem_q;

endmodule : tdpt_div

`default_nettype wire
